### rtl/core/gcd_pkg.sv
package gcd_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int ATAN_LEN = 40;
	localparam int XY_W = 33;               // CORDIC x/y, Q30 signed with headroom
	localparam int ANG_W = 34;              // CORDIC z, 2^-32 turn signed
	localparam int QUEUE_DEPTH = 4;
	localparam logic signed [XY_W-1:0] CORDIC_START = 33'sd652032874;
	localparam logic [ANG_W-2:0] QUARTER_TURN = 33'd1073741824;
	localparam logic [31:0] CIRC_Q16 = 32'd2623417457;  // 2*pi*6371 km, Q16
	localparam logic [25:0] RECIP_45 = 26'd47721858;    // floor(2^31 / 45)
	localparam int RECIP_SHIFT = 31;

	// Four binary angles, one item in the front/back queue.
	typedef struct packed {
		logic [31:0] lat1;
		logic [31:0] lon1;
		logic [31:0] lat2;
		logic [31:0] lon2;
	} ang_set_t;

	typedef logic [12:0] rem_tbl_t [45];

	// floor((b*16384 + 45) / 90): rounded tail of the degree-to-angle scale
	function automatic rem_tbl_t rem_table();
		rem_tbl_t t;
		for (int b = 0; b < 45; b++) begin
			t[b] = 13'((b * 16384 + 45) / 90);
		end
		return t;
	endfunction

	function automatic logic signed [ANG_W-1:0] atan_bam(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return $signed({2'b00, v});
	endfunction

endpackage

### rtl/core/gcd_front.sv
module gcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [103:0]        s_tdata,
	output logic                push,
	output gcd_pkg::ang_set_t   push_data,
	input  logic                full
);

	localparam gcd_pkg::rem_tbl_t REM_TBL = gcd_pkg::rem_table();
	localparam int RECIP_SHIFT_HI = gcd_pkg::RECIP_SHIFT + 18;

	logic        f_en;
	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [24:0] coord [4];
	logic        sgn_s1 [4], sgn_s2 [4], sgn_s3 [4];
	logic [24:0] mag_s1 [4], mag_s2 [4];
	logic [50:0] prod_s2 [4];
	logic [18:0] quo_s3 [4];
	logic [5:0]  rem_s3 [4];
	logic [31:0] bam_s4 [4];

	assign coord[0] = {s_tdata[23], s_tdata[23:0]};
	assign coord[1] = s_tdata[48:24];
	assign coord[2] = {s_tdata[72], s_tdata[72:49]};
	assign coord[3] = s_tdata[97:73];

	assign f_en     = !vld_s4 || !full;
	assign s_tready = f_en;
	assign push     = vld_s4 && !full;
	assign push_data = '{lat1: bam_s4[0], lon1: bam_s4[1], lat2: bam_s4[2], lon2: bam_s4[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (f_en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// |deg16| * 65536 / 360 rounded = 8192*q + tbl[r] with |deg16| = 45q + r
	for (genvar c = 0; c < 4; c++) begin : g_coord
		logic [18:0] q0;
		logic [25:0] r0;
		logic [31:0] qv;

		always_comb begin
			q0 = prod_s2[c][RECIP_SHIFT_HI:gcd_pkg::RECIP_SHIFT];
			r0 = 26'(mag_s2[c]) - 26'(q0) * 26'd45;
			qv = {quo_s3[c], 13'd0} + 32'(REM_TBL[rem_s3[c]]);
		end

		always_ff @(posedge clk) begin
			if (f_en) begin
				sgn_s1[c] <= coord[c][24];
				mag_s1[c] <= coord[c][24] ? 25'(-coord[c]) : coord[c];
				sgn_s2[c] <= sgn_s1[c];
				mag_s2[c] <= mag_s1[c];
				prod_s2[c] <= 51'(mag_s1[c]) * 51'(gcd_pkg::RECIP_45);
				sgn_s3[c] <= sgn_s2[c];
				if (r0 >= 26'd45) begin
					quo_s3[c] <= q0 + 19'd1;
					rem_s3[c] <= 6'(r0 - 26'd45);
				end else begin
					quo_s3[c] <= q0;
					rem_s3[c] <= r0[5:0];
				end
				bam_s4[c] <= sgn_s3[c] ? -qv : qv;
			end
		end
	end

endmodule

### rtl/core/gcd_queue.sv
module gcd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gcd_pkg::ang_set_t push_data,
	input  logic              pop,
	output gcd_pkg::ang_set_t head,
	output logic              empty,
	output logic              full
);

	localparam int AW = $clog2(gcd_pkg::QUEUE_DEPTH);

	gcd_pkg::ang_set_t mem [gcd_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (AW+1)'(gcd_pkg::QUEUE_DEPTH));
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

### rtl/core/gcd_back.sv
module gcd_back #(
	parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gcd_pkg::ang_set_t head,
	input  logic              empty,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata
);

	localparam int XW = gcd_pkg::XY_W;
	localparam int ZW = gcd_pkg::ANG_W;
	localparam int N = CORDIC_STEPS;
	localparam int SQ_STEPS = 31;
	// valid shift register ends beside prod_s1; m_tvalid then sits with dist_q
	localparam int LAT = 2 * N + 36;

	function automatic logic signed [34:0] mul_q30(input logic signed [34:0] p,
		input logic signed [34:0] q);
		logic signed [69:0] pr;
		pr = 70'(p) * 70'(q) + 70'sd536870912;
		return pr[64:30];
	endfunction

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [XW-1:0] rot_x_s [4][N+1];
	logic signed [XW-1:0] rot_y_s [4][N+1];
	logic signed [ZW-1:0] rot_z_s [4][N+1];
	logic                 rot_flip_s [4][N+1];

	logic signed [34:0] hl_s1, hn_s1, cc_s1, hl_s2, t_s2;
	logic signed [35:0] a_sum;
	logic [30:0]        a_clamp;

	logic [60:0] sqv_s [2][SQ_STEPS+1];
	logic [60:0] sqr_s [2][SQ_STEPS+1];

	logic signed [XW-1:0] vec_x_s [N];
	logic signed [XW-1:0] vec_y_s [N];
	logic signed [ZW-1:0] vec_z_s [N];

	logic [30:0] theta;
	logic [62:0] prod_s1;
	logic [63:0] dist_sum;
	logic [22:0] dist_q;

	logic [31:0] dlat, dlon;
	logic [31:0] ang_in [4];

	assign en  = !m_tvalid || m_tready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q    <= {vld_q[LAT-2:0], !empty};
			m_tvalid <= vld_q[LAT-1];
		end
	end

	// stage 0: half differences for the sin^2 terms, raw latitudes for cos
	assign dlat = head.lat2 - head.lat1;
	assign dlon = head.lon2 - head.lon1;
	assign ang_in[0] = {1'b0, dlat[31:1]};
	assign ang_in[1] = {1'b0, dlon[31:1]};
	assign ang_in[2] = head.lat1;
	assign ang_in[3] = head.lat2;

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic signed [ZW-1:0] z0, zf;
		logic                 fl;

		always_comb begin
			z0 = ZW'($signed(ang_in[l]));
			zf = z0;
			fl = 1'b0;
			// fold into a quarter turn either side of zero
			if (z0 > $signed({1'b0, gcd_pkg::QUARTER_TURN})) begin
				zf = z0 - ZW'(64'sd2147483648);
				fl = 1'b1;
			end else if (z0 < -$signed({1'b0, gcd_pkg::QUARTER_TURN})) begin
				zf = z0 + ZW'(64'sd2147483648);
				fl = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rot_x_s[l][0]    <= gcd_pkg::CORDIC_START;
				rot_y_s[l][0]    <= '0;
				rot_z_s[l][0]    <= zf;
				rot_flip_s[l][0] <= fl;
			end
		end

		for (genvar i = 0; i < N; i++) begin : g_step
			localparam logic signed [ZW-1:0] ATAN = gcd_pkg::atan_bam(i);
			logic signed [XW-1:0] dx, dy, xn, yn;
			logic signed [ZW-1:0] zn;

			always_comb begin
				dx = rot_y_s[l][i] >>> i;
				dy = rot_x_s[l][i] >>> i;
				if (!rot_z_s[l][i][ZW-1]) begin
					xn = rot_x_s[l][i] - dx;
					yn = rot_y_s[l][i] + dy;
					zn = rot_z_s[l][i] - ATAN;
				end else begin
					xn = rot_x_s[l][i] + dx;
					yn = rot_y_s[l][i] - dy;
					zn = rot_z_s[l][i] + ATAN;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rot_z_s[l][i+1]    <= zn;
					rot_flip_s[l][i+1] <= rot_flip_s[l][i];
					if (i == N - 1 && rot_flip_s[l][i]) begin
						rot_x_s[l][i+1] <= -xn;
						rot_y_s[l][i+1] <= -yn;
					end else begin
						rot_x_s[l][i+1] <= xn;
						rot_y_s[l][i+1] <= yn;
					end
				end
			end
		end
	end

	// haversine term a, then the radicands of sqrt(a) and sqrt(1-a)
	always_comb begin
		a_sum = 36'(hl_s2) + 36'(t_s2);
		if (a_sum < 0) begin
			a_clamp = '0;
		end else if (a_sum > 36'sd1073741824) begin
			a_clamp = 31'(gcd_pkg::QUARTER_TURN);
		end else begin
			a_clamp = a_sum[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hl_s1 <= mul_q30(35'(rot_y_s[0][N]), 35'(rot_y_s[0][N]));
			hn_s1 <= mul_q30(35'(rot_y_s[1][N]), 35'(rot_y_s[1][N]));
			cc_s1 <= mul_q30(35'(rot_x_s[2][N]), 35'(rot_x_s[3][N]));
			hl_s2 <= hl_s1;
			t_s2  <= mul_q30(cc_s1, hn_s1);
			sqv_s[0][0] <= {a_clamp, 30'd0};
			sqv_s[1][0] <= {31'(gcd_pkg::QUARTER_TURN) - a_clamp, 30'd0};
			sqr_s[0][0] <= '0;
			sqr_s[1][0] <= '0;
		end
	end

	// bit-by-bit integer square root, one result bit per stage
	for (genvar r = 0; r < 2; r++) begin : g_root
		for (genvar k = 0; k < SQ_STEPS; k++) begin : g_bit
			localparam logic [60:0] BIT = 61'(1) << (60 - 2 * k);
			logic [60:0] rb;

			assign rb = sqr_s[r][k] + BIT;

			always_ff @(posedge clk) begin
				if (en) begin
					if (sqv_s[r][k] >= rb) begin
						sqv_s[r][k+1] <= sqv_s[r][k] - rb;
						sqr_s[r][k+1] <= (sqr_s[r][k] >> 1) + BIT;
					end else begin
						sqv_s[r][k+1] <= sqv_s[r][k];
						sqr_s[r][k+1] <= sqr_s[r][k] >> 1;
					end
				end
			end
		end
	end

	// vectoring CORDIC: atan2(sqrt(a), sqrt(1-a)) as a binary angle
	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic signed [ZW-1:0] ATAN = gcd_pkg::atan_bam(i);
		logic signed [XW-1:0] xs, ys;
		logic signed [ZW-1:0] zs;

		if (i == 0) begin : g_first
			assign xs = $signed({2'b00, sqr_s[1][SQ_STEPS][30:0]});
			assign ys = $signed({2'b00, sqr_s[0][SQ_STEPS][30:0]});
			assign zs = '0;
		end else begin : g_next
			assign xs = vec_x_s[i-1];
			assign ys = vec_y_s[i-1];
			assign zs = vec_z_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (ys > 0) begin
					vec_x_s[i] <= xs + (ys >>> i);
					vec_y_s[i] <= ys - (xs >>> i);
					vec_z_s[i] <= zs + ATAN;
				end else begin
					vec_x_s[i] <= xs - (ys >>> i);
					vec_y_s[i] <= ys + (xs >>> i);
					vec_z_s[i] <= zs - ATAN;
				end
			end
		end
	end

	always_comb begin
		if (vec_z_s[N-1] < 0) begin
			theta = '0;
		end else if (vec_z_s[N-1] > $signed({1'b0, gcd_pkg::QUARTER_TURN})) begin
			theta = 31'(gcd_pkg::QUARTER_TURN);
		end else begin
			theta = vec_z_s[N-1][30:0];
		end
		dist_sum = 64'(prod_s1) + (64'(1) << 38);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 63'(theta) * 63'(gcd_pkg::CIRC_Q16);
			dist_q  <= dist_sum[61:39];
		end
	end

	assign m_tdata = {1'b0, dist_q};

endmodule

### rtl/core/great_circle_distance.sv
// Throughput: one word per cycle unless the output word waits; every stage
//   is pipelined, the slowest being one isqrt bit or one CORDIC micro-rotation
//   per stage.
// Reset: arst_n clears all valid bits and queue pointers asynchronously;
//   datapath registers are not reset.
module great_circle_distance #(
	parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_latitude[23:0], first_longitude[48:24], second_latitude[72:49],
	// second_longitude[97:73], zero pad [103:98]
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// distance_km[22:0] (km, 8 fraction bits), zero pad [23]
	output logic [23:0]  m_tdata
);

	// Front: four coordinates to binary angles (2^-32 turn), 4 stages.
	// Queue: 4 words, decouples front stalls from the back pipeline.
	// Back: four rotation CORDICs, haversine products, two 31-stage
	//   roots, a vectoring CORDIC and the circumference scaling. The whole
	//   back moves as one pipeline, held only while the output word waits.

	logic              push, pop, empty, full;
	gcd_pkg::ang_set_t push_data, head;

	gcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	gcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	gcd_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### rtl/core/gcd_checker.sv
module gcd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [103:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [23:0]  m_tdata
);

	logic [9:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]);
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 10'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 10'd1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result word dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result word changed");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= 24'd5123862) else $error("distance above half circumference");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 10'd0) else $error("result without input word");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);

### test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = gcd_pkg::CORDIC_STEPS_DEF;
	localparam int LATENCY = 2 * STEPS + 42;

	// One input word: two points, degrees with 16 fraction bits.
	typedef struct {
		logic signed [23:0] lat1;
		logic signed [24:0] lon1;
		logic signed [23:0] lat2;
		logic signed [24:0] lon2;
	} point_pair_t;

	// CORDIC arctangent steps in 2^-32 turn
	localparam longint ARC_STEP [40] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// first_latitude, first_longitude, second_latitude, second_longitude, pad
	logic [103:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// distance_km, pad
	logic [23:0] m_tdata;

	point_pair_t pending_pairs[$];
	logic [22:0] expected_km[$];
	point_pair_t on_bus;
	int words_sent = 0;
	int total_words = 0;
	int mismatches = 0;
	int send_idle_pct = 20;
	int recv_idle_pct = 46;
	bit stim_done = 1'b0;

	great_circle_distance i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ---- predictor -------------------------------------------------------

	// degrees Q16 to binary angle, rounded half away from zero, mod 2^32
	function automatic logic [31:0] deg_to_turn(longint deg16);
		longint n, m, q;
		n = deg16 * 65536;
		m = n < 0 ? -n : n;
		q = (m + 180) / 360;
		if (n < 0) q = -q;
		return q[31:0];
	endfunction

	function automatic longint q30_mul(longint p, longint q);
		return (p * q + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// rotation CORDIC with quarter-turn folding; Q30 sine and cosine
	function automatic void rotate_unit(input logic [31:0] ang, output longint sn,
		output longint cs);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(ang);
		x = 652032874;
		y = 0;
		flip = 1'b0;
		if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
		if (z > (64'sd1 <<< 30)) begin
			z -= (64'sd1 <<< 31);
			flip = 1'b1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += (64'sd1 <<< 31);
			flip = 1'b1;
		end
		for (int i = 0; i < STEPS && i < 40; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARC_STEP[i];
			end else begin
				x += dx; y -= dy; z += ARC_STEP[i];
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endfunction

	// vectoring CORDIC: atan2(y, x) in 2^-32 turn, clamped to a quarter turn
	function automatic longint half_angle(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < STEPS && i < 40; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ARC_STEP[i];
			end else begin
				x -= dx; y += dy; z -= ARC_STEP[i];
			end
		end
		if (z < 0) z = 0;
		if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
		return z;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [22:0] haversine_km(point_pair_t p);
		logic [31:0] bl1, bo1, bl2, bo2, dlat, dlon;
		longint s1, s2, c1, c2, dummy, a, theta;
		longint unsigned ry, rx, km_q8;
		bl1 = deg_to_turn(longint'(p.lat1));
		bo1 = deg_to_turn(longint'(p.lon1));
		bl2 = deg_to_turn(longint'(p.lat2));
		bo2 = deg_to_turn(longint'(p.lon2));
		dlat = bl2 - bl1;
		dlon = bo2 - bo1;
		rotate_unit(dlat >> 1, s1, dummy);
		rotate_unit(dlon >> 1, s2, dummy);
		rotate_unit(bl1, dummy, c1);
		rotate_unit(bl2, dummy, c2);
		a = q30_mul(s1, s1) + q30_mul(q30_mul(c1, c2), q30_mul(s2, s2));
		if (a < 0) a = 0;
		if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
		ry = floor_root(longint'(a) << 30);
		rx = floor_root(((64'd1 << 30) - a) << 30);
		theta = half_angle(longint'(rx), longint'(ry));
		km_q8 = (longint'(theta) * 64'd2623417457 + (64'd1 << 38)) >> 39;
		return km_q8[22:0];
	endfunction

	// ---- stimulus --------------------------------------------------------

	function automatic point_pair_t pair_of(int la1, int lo1, int la2, int lo2);
		point_pair_t p;
		p.lat1 = 24'(la1); p.lon1 = 25'(lo1); p.lat2 = 24'(la2); p.lon2 = 25'(lo2);
		return p;
	endfunction

	task automatic add_pair(input point_pair_t p);
		pending_pairs = {pending_pairs, p};
	endtask

	// random coordinate: mostly on the globe, sometimes any field value
	function automatic int coord(int bits, int span);
		if ($urandom_range(9) == 0)
			return int'($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
		return int'($urandom_range(2 * span)) - span;
	endfunction

	localparam int LAT_MAX = 90 << 16;
	localparam int LON_MAX = 180 << 16;

	initial begin
		point_pair_t p;
		// same point, poles, antipodes (distance saturates)
		add_pair(pair_of(0, 0, 0, 0));
		add_pair(pair_of(0, 0, 0, LON_MAX));
		add_pair(pair_of(0, -LON_MAX, 0, LON_MAX));
		add_pair(pair_of(LAT_MAX, 0, -LAT_MAX, 0));
		add_pair(pair_of(LAT_MAX, 123, LAT_MAX, -LON_MAX));
		add_pair(pair_of(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX));
		add_pair(pair_of(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 2, -2 * LON_MAX / 3));
		// nearly antipodal, tiny offsets
		add_pair(pair_of(1, 0, -1, LON_MAX));
		add_pair(pair_of(0, 0, 1, 1));
		add_pair(pair_of(-1, -1, 0, 0));
		// out-of-range angles wrap; full field extremes
		add_pair(pair_of(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1));
		add_pair(pair_of((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24)));
		add_pair(pair_of(-1, -1, -1, -1));
		add_pair(pair_of(LAT_MAX + 65536, LON_MAX + 65536, 0, 0));
		add_pair(pair_of(51 << 16, 0, 40 << 16, -(74 << 16)));
		for (int k = 0; k < 1900; k++) begin
			case ($urandom_range(3))
				0: p = pair_of(coord(24, LAT_MAX), coord(25, LON_MAX),
					coord(24, LAT_MAX), coord(25, LON_MAX));
				1: begin
					// short hops around a random point
					p = pair_of(coord(24, LAT_MAX), coord(25, LON_MAX), 0, 0);
					p.lat2 = p.lat1 + $signed(24'($urandom_range(4096) - 2048));
					p.lon2 = p.lon1 + $signed(25'($urandom_range(4096) - 2048));
				end
				2: begin
					// near antipodes, close to saturation
					p = pair_of(coord(24, LAT_MAX), coord(25, LON_MAX), 0, 0);
					p.lat2 = -p.lat1 + $signed(24'($urandom_range(2048) - 1024));
					p.lon2 = 25'(p.lon1 + (p.lon1 < 0 ? LON_MAX : -LON_MAX)
						+ $signed(25'($urandom_range(2048) - 1024)));
				end
				default: p = pair_of(int'($urandom) >>> 8, int'($urandom) >>> 7,
					int'($urandom) >>> 8, int'($urandom) >>> 7);
			endcase
			add_pair(p);
		end
		total_words = pending_pairs.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && expected_km.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	// ---- driver: one word per handshake, random gaps by phase ------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_km = {expected_km, haversine_km(on_bus)};
				words_sent++;
				// idling phases: receiver-heavy, then sender-heavy, then none
				if (words_sent == total_words / 3) begin
					send_idle_pct = 46;
					recv_idle_pct = 20;
				end else if (words_sent == 2 * total_words / 3) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				if (words_sent == total_words) stim_done = 1'b1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending_pairs.pop_front();
					s_tdata <= {6'b0, on_bus.lon2, on_bus.lat2, on_bus.lon1, on_bus.lat1};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---- monitor: compare each result word with the oldest expectation --
	always @(posedge clk) begin
		logic [22:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_km.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: distance_km %0d", m_tdata[22:0]);
			end else begin
				want = expected_km.pop_front();
				if (m_tdata[22:0] !== want || m_tdata[23] !== 1'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("distance_km mismatch: expected %0d, got %0d (pad %b)",
							want, m_tdata[22:0], m_tdata[23]);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("testbench: errors");
		$finish;
	end

endmodule
